/* rtl/core/expression_lexer_defines.svh */
// Assertion macros shared by the lexer RTL.
`ifndef EXPRESSION_LEXER_DEFINES_SVH
`define EXPRESSION_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define EL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define EL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define EL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define EL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/el_pkg.sv */
package el_pkg;

    localparam int POS_W = 16;
    localparam int VAL_W = 64;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [VAL_W-1:0] t_value;
    typedef logic [1:0]       t_kind;

    localparam t_kind KIND_NUM   = 2'd0;
    localparam t_kind KIND_PUNCT = 2'd1;
    localparam t_kind KIND_END   = 2'd2;
    localparam t_kind KIND_ERR   = 2'd3;

    // One token as it travels through the result queue.
    typedef struct packed {
        t_kind      kind;
        t_value     value;
        logic [7:0] first_char;
        logic [7:0] second_char;
        t_pos       start_pos;
        t_pos       length;
        logic       last;
    } t_result;

    // Increment that sticks at all ones.
    function automatic t_pos sat_inc(input t_pos v);
        t_pos r;
        r = (v == '1) ? v : t_pos'(v + 1'b1);
        return r;
    endfunction

endpackage

/* rtl/core/el_in_if.sv */
interface el_in_if;
    import el_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source(output valid, output char_code, output end_of_text, input ready);
    modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

/* rtl/core/el_out_if.sv */
interface el_out_if;
    import el_pkg::*;

    logic       valid;
    logic       ready;
    t_kind      token_class;
    t_value     number_value;
    logic [7:0] first_char;
    logic [7:0] second_char;
    t_pos       start_pos;
    t_pos       token_length;
    logic       last_of_run;

    modport source(output valid, output token_class, output number_value,
                   output first_char, output second_char, output start_pos,
                   output token_length, output last_of_run, input ready);
    modport sink(input valid, input token_class, input number_value,
                 input first_char, input second_char, input start_pos,
                 input token_length, input last_of_run, output ready);
endinterface

/* rtl/core/expression_lexer.sv */
// A token caused by a byte is written into the result queue when that byte's word is accepted.
// One byte per cycle while each byte yields at most one token and the output keeps up; a byte that
// yields two tokens fills two slots of the four-entry result queue in the same cycle.
// The input is ready whenever the queue has two free slots, so both tokens of a byte always fit.
// Reset (i_rst_n low at a rising edge) empties the queue and returns the lexer to offset zero.
`include "expression_lexer_defines.svh"

module expression_lexer (
    input  logic     i_clk,
    input  logic     i_rst_n,
    el_in_if.sink    i_in_ch,
    el_out_if.source o_out_ch
);
    import el_pkg::*;

    // Pending-token codes of the lexer state.
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_NUM   = 2'd1;
    localparam logic [1:0] PEND_PUNCT = 2'd2;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Character classes. Punctuators are the printable non-alphanumeric characters.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic may_pair(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
    endfunction

    // Lexer state. These registers double as the input side of the single pass:
    // each accepted word is combined with them and the tokens land in the queue.
    logic [1:0] r_pend, n_pend;
    t_pos       r_pos, n_pos;
    t_value     r_acc, n_acc;
    t_pos       r_start, n_start;
    t_pos       r_len, n_len;
    logic [7:0] r_char, n_char;
    logic       r_discard, n_discard;

    // Result queue.
    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_in_acc;
    logic w_out_acc;

    assign i_in_ch.ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign w_in_acc      = i_in_ch.valid && i_in_ch.ready;
    assign w_out_acc     = o_out_ch.valid && o_out_ch.ready;

    logic [7:0] w_c;
    logic [3:0] w_digit;
    assign w_c     = i_in_ch.char_code;
    assign w_digit = 4'(w_c - CH_ZERO);

    // Decimal accumulate as two shifted copies plus the digit. Any carry into
    // the top four bits means the value went past all ones and saturates.
    logic [VAL_W+3:0] w_acc_x10;
    t_value           w_acc_next;
    assign w_acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                        (VAL_W + 4)'(w_digit);
    assign w_acc_next = (w_acc_x10[VAL_W+3:VAL_W] != 4'b0) ? '1 : w_acc_x10[VAL_W-1:0];

    // Token that a flush of the pending state would give.
    t_result w_flush;
    logic    w_flush_vld;
    always_comb begin
        w_flush             = '0;
        w_flush.start_pos   = r_start;
        w_flush_vld         = (r_pend != PEND_NONE);
        if (r_pend == PEND_NUM) begin
            w_flush.kind   = KIND_NUM;
            w_flush.value  = r_acc;
            w_flush.length = r_len;
        end else begin
            w_flush.kind       = KIND_PUNCT;
            w_flush.first_char = r_char;
            w_flush.length     = t_pos'(1);
        end
    end

    // Per-word lexer step. Up to two tokens come out: an older one (the flushed
    // pending token) and a newer one (the token this byte makes on its own).
    t_result    w_old, w_new;
    logic       w_old_vld, w_new_vld;
    t_result    w_res0, w_res1;
    logic [1:0] w_push;

    always_comb begin
        n_pend    = r_pend;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_start   = r_start;
        n_len     = r_len;
        n_char    = r_char;
        n_discard = r_discard;
        w_old     = w_flush;
        w_old_vld = 1'b0;
        w_new     = '0;
        w_new_vld = 1'b0;

        if (i_in_ch.end_of_text) begin
            // The end mark closes the pending token unless the text already failed,
            // then reports its own offset and starts a fresh text.
            w_old_vld        = w_flush_vld && !r_discard;
            w_new_vld        = 1'b1;
            w_new.kind       = KIND_END;
            w_new.start_pos  = r_pos;
            n_pend           = PEND_NONE;
            n_pos            = '0;
            n_acc            = '0;
            n_start          = '0;
            n_len            = '0;
            n_char           = '0;
            n_discard        = 1'b0;
        end else if (r_discard) begin
            n_pos = sat_inc(r_pos);
        end else begin
            n_pos = sat_inc(r_pos);
            if (r_pend == PEND_PUNCT && w_c == CH_EQ) begin
                w_new_vld         = 1'b1;
                w_new.kind        = KIND_PUNCT;
                w_new.first_char  = r_char;
                w_new.second_char = CH_EQ;
                w_new.start_pos   = r_start;
                w_new.length      = t_pos'(2);
                n_pend            = PEND_NONE;
                n_char            = '0;
            end else if (r_pend == PEND_NUM && is_digit(w_c)) begin
                n_acc = w_acc_next;
                n_len = sat_inc(r_len);
            end else begin
                w_old_vld = w_flush_vld;
                n_pend    = PEND_NONE;
                n_acc     = '0;
                n_len     = '0;
                n_char    = '0;
                if (is_space(w_c)) begin
                    n_pend = PEND_NONE;
                end else if (is_digit(w_c)) begin
                    n_pend  = PEND_NUM;
                    n_acc   = VAL_W'(w_digit);
                    n_start = r_pos;
                    n_len   = t_pos'(1);
                end else if (may_pair(w_c)) begin
                    // Hold the character one byte to see whether '=' follows.
                    n_pend  = PEND_PUNCT;
                    n_char  = w_c;
                    n_start = r_pos;
                end else if (is_punct(w_c)) begin
                    w_new_vld        = 1'b1;
                    w_new.kind       = KIND_PUNCT;
                    w_new.first_char = w_c;
                    w_new.start_pos  = r_pos;
                    w_new.length     = t_pos'(1);
                end else begin
                    // Bad byte: report it and drop everything up to the end mark.
                    w_new_vld        = 1'b1;
                    w_new.kind       = KIND_ERR;
                    w_new.first_char = w_c;
                    w_new.start_pos  = r_pos;
                    w_new.length     = t_pos'(1);
                    n_discard        = 1'b1;
                end
            end
        end

        // Pack the tokens into queue order and mark the last one of the word.
        w_res1      = w_new;
        w_res1.last = 1'b1;
        if (w_old_vld) begin
            w_res0      = w_old;
            w_res0.last = !w_new_vld;
            w_push      = w_new_vld ? 2'd2 : 2'd1;
        end else begin
            w_res0      = w_new;
            w_res0.last = 1'b1;
            w_push      = w_new_vld ? 2'd1 : 2'd0;
        end
        if (!w_in_acc) begin
            w_push = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= PEND_NONE;
            r_pos     <= '0;
            r_acc     <= '0;
            r_start   <= '0;
            r_len     <= '0;
            r_char    <= '0;
            r_discard <= 1'b0;
        end else if (w_in_acc) begin
            r_pend    <= n_pend;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_start   <= n_start;
            r_len     <= n_len;
            r_char    <= n_char;
            r_discard <= n_discard;
        end
    end

    // Queue storage: the first token goes to the write pointer, a second one
    // to the slot after it.
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_fifo[PTR_W'(r_wr_ptr + 1'b1)] <= w_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= PTR_W'(r_wr_ptr + PTR_W'(w_push));
            r_rd_ptr <= PTR_W'(r_rd_ptr + PTR_W'(w_out_acc));
            r_count  <= CNT_W'(r_count + CNT_W'(w_push) - CNT_W'(w_out_acc));
        end
    end

    // The head of the queue drives the output word.
    t_result w_head;
    assign w_head                = r_fifo[r_rd_ptr];
    assign o_out_ch.valid        = (r_count != '0);
    assign o_out_ch.token_class  = w_head.kind;
    assign o_out_ch.number_value = w_head.value;
    assign o_out_ch.first_char   = w_head.first_char;
    assign o_out_ch.second_char  = w_head.second_char;
    assign o_out_ch.start_pos    = w_head.start_pos;
    assign o_out_ch.token_length = w_head.length;
    assign o_out_ch.last_of_run  = w_head.last;

    // The queue never holds more than its depth.
    `EL_ASSERT_IMPLIES(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    // A failed text never keeps a pending token.
    `EL_ASSERT_IMPLIES(a_discard_clean, i_clk, i_rst_n, r_discard, r_pend == PEND_NONE)
    // An end mark leaves the lexer at the start of a fresh text.
    `EL_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, w_in_acc && i_in_ch.end_of_text, r_pos == '0 && r_pend == PEND_NONE && !r_discard)
    // The second token of a pair was queued together with the first.
    `EL_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, w_out_acc && !o_out_ch.last_of_run, o_out_ch.valid)

endmodule
